FILE: rtl/core/jsu_pkg.sv
`timescale 1ns / 1ps
package jsu_pkg;

  // Decoder phase
  typedef enum logic [3:0] {
    PH_WAIT = 4'd0,
    PH_STR  = 4'd1,
    PH_ESC  = 4'd2,
    PH_HEX1 = 4'd3,
    PH_BSL  = 4'd4,
    PH_U    = 4'd5,
    PH_HEX2 = 4'd6
  } phase_t;

  // Result kind
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // Error codes
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_NO_QUOTE   = 4'd0;
  localparam logic [3:0] ERR_CONTROL    = 4'd1;
  localparam logic [3:0] ERR_ESC_CUT    = 4'd2;
  localparam logic [3:0] ERR_BAD_ESC    = 4'd3;
  localparam logic [3:0] ERR_HEX_CUT    = 4'd4;
  localparam logic [3:0] ERR_NON_HEX    = 4'd5;
  localparam logic [3:0] ERR_LONE_HIGH  = 4'd6;
  localparam logic [3:0] ERR_BAD_PAIR   = 4'd7;
  localparam logic [3:0] ERR_LONE_LOW   = 4'd8;
  localparam logic [3:0] ERR_UNTERM     = 4'd9;

  // Characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam int MAX_RES = 4;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [3:0] code;
  } jsu_res_t;

  // Results of one input item
  typedef struct packed {
    logic [2:0]                  count;
    jsu_res_t [MAX_RES-1:0]      res;
  } jsu_dec_t;

  function automatic jsu_res_t mk_res(input kind_t k, input logic [7:0] b,
                                      input logic [3:0] c);
    jsu_res_t r;
    r.kind = k;
    r.data = b;
    r.code = c;
    return r;
  endfunction

  // Hex digit: bit 4 set when valid
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  // Encode a code point as 1 to 4 UTF-8 bytes
  function automatic jsu_dec_t utf8_enc(input logic [20:0] cp);
    jsu_dec_t o;
    o = '0;
    if (cp <= 21'h7F) begin
      o.count  = 3'd1;
      o.res[0] = mk_res(KIND_BYTE, cp[7:0], ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      o.count  = 3'd2;
      o.res[0] = mk_res(KIND_BYTE, 8'hC0 | {3'b0, cp[10:6]}, ERR_NONE);
      o.res[1] = mk_res(KIND_BYTE, 8'h80 | {2'b0, cp[5:0]}, ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      o.count  = 3'd3;
      o.res[0] = mk_res(KIND_BYTE, 8'hE0 | {4'b0, cp[15:12]}, ERR_NONE);
      o.res[1] = mk_res(KIND_BYTE, 8'h80 | {2'b0, cp[11:6]}, ERR_NONE);
      o.res[2] = mk_res(KIND_BYTE, 8'h80 | {2'b0, cp[5:0]}, ERR_NONE);
    end else begin
      o.count  = 3'd4;
      o.res[0] = mk_res(KIND_BYTE, 8'hF0 | {5'b0, cp[20:18]}, ERR_NONE);
      o.res[1] = mk_res(KIND_BYTE, 8'h80 | {2'b0, cp[17:12]}, ERR_NONE);
      o.res[2] = mk_res(KIND_BYTE, 8'h80 | {2'b0, cp[11:6]}, ERR_NONE);
      o.res[3] = mk_res(KIND_BYTE, 8'h80 | {2'b0, cp[5:0]}, ERR_NONE);
    end
    return o;
  endfunction

endpackage

FILE: rtl/core/json_string_unescaper_unit.sv
`timescale 1ns / 1ps
// Channel | Direction | tdata (low bit up)                 | tuser      | tlast
// in_     | slave     | [7:0] in_byte                      | in_end     | -
// out_    | master    | [7:0] out_byte, [11:8] error_code  | out_kind   | last
//
// One input byte per cycle unless the input is held. Results pass the input
// register, then a four-entry result register, and leave one per cycle while
// out_tready is high, so a \u escape that encodes to k UTF-8 bytes holds the
// next byte that gives a result until its last byte is draining; bytes that
// give no result keep flowing meanwhile. Reset (rst_n low, synchronous)
// returns the decoder to waiting for a quote and drops any pending results.
// A stalled output holds the input side once the input register holds a byte
// that gives a result and the result register is not empty.
module json_string_unescaper_unit import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] in_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [11:8] error_code, [15:12] zero
  output logic [1:0]  out_tuser,  // [1:0] out_kind
  output logic        out_tlast   // last result of an input item
);

  logic                    in_valid_r;
  logic [7:0]              in_byte_r;
  logic                    in_end_r;
  jsu_res_t [MAX_RES-1:0]  res_r;
  logic [2:0]              cnt_r;
  logic                    room;
  logic                    process;
  logic                    load_res;
  logic                    out_xfer;
  jsu_dec_t                dec;

  assign out_xfer  = out_tvalid && out_tready;
  // Result register is empty or draining its last entry
  assign room      = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_tready);
  // Decode when there is room, or when the byte gives no result
  assign process   = in_valid_r && (room || (dec.count == 3'd0));
  assign load_res  = process && room;
  assign in_tready = !in_valid_r || process;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tuser;
    end
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (process),
    .in_byte (in_byte_r),
    .in_end  (in_end_r),
    .dec     (dec)
  );

  // Result count: load on decode, count down on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (load_res) begin
      cnt_r <= dec.count;
    end else if (out_xfer) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // Result register: load all results, shift down on transfer
  always_ff @(posedge clk) begin
    if (load_res) begin
      res_r <= dec.res;
    end else if (out_xfer) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        res_r[i] <= res_r[i+1];
      end
    end
  end

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {4'd0, res_r[0].code, res_r[0].data};
  assign out_tuser  = res_r[0].kind;
  assign out_tlast  = (cnt_r == 3'd1);

endmodule

FILE: rtl/core/jsu_decode.sv
`timescale 1ns / 1ps
module jsu_decode import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output jsu_dec_t   dec
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hex_count_r, hex_count_nxt;
  logic [15:0] high_unit_r, high_unit_nxt;
  logic [15:0] hex_accum_r, hex_accum_nxt;

  logic [4:0]  hd;
  logic [15:0] quad;
  logic [20:0] pair_cp;

  assign hd      = hex_digit(in_byte);
  assign quad    = {hex_accum_r[11:0], hd[3:0]};
  assign pair_cp = 21'h10000 + {1'b0, high_unit_r[9:0], quad[9:0]};

  // Next state and results for the current byte
  always_comb begin
    phase_nxt     = phase_r;
    hex_count_nxt = hex_count_r;
    high_unit_nxt = high_unit_r;
    hex_accum_nxt = hex_accum_r;
    dec           = '0;
    case (phase_r)
      PH_STR: begin
        if (in_end) begin
          dec.count = 3'd1; dec.res[0] = mk_res(KIND_ERR, 8'd0, ERR_UNTERM);
          phase_nxt = PH_WAIT; hex_count_nxt = 2'd0;
        end else if (in_byte == CH_QUOTE) begin
          dec.count = 3'd1; dec.res[0] = mk_res(KIND_DONE, 8'd0, ERR_NONE);
          phase_nxt = PH_WAIT;
        end else if (in_byte < CTRL_LIMIT) begin
          dec.count = 3'd1; dec.res[0] = mk_res(KIND_ERR, 8'd0, ERR_CONTROL);
          phase_nxt = PH_WAIT; hex_count_nxt = 2'd0;
        end else if (in_byte == CH_BSLASH) begin
          phase_nxt = PH_ESC;
        end else begin
          dec.count = 3'd1; dec.res[0] = mk_res(KIND_BYTE, in_byte, ERR_NONE);
        end
      end
      PH_ESC: begin
        if (in_end) begin
          dec.count = 3'd1; dec.res[0] = mk_res(KIND_ERR, 8'd0, ERR_ESC_CUT);
          phase_nxt = PH_WAIT; hex_count_nxt = 2'd0;
        end else begin
          phase_nxt = PH_STR;
          dec.count = 3'd1;
          case (in_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH:
              dec.res[0] = mk_res(KIND_BYTE, in_byte, ERR_NONE);
            CH_B: dec.res[0] = mk_res(KIND_BYTE, 8'h08, ERR_NONE);
            CH_F: dec.res[0] = mk_res(KIND_BYTE, 8'h0C, ERR_NONE);
            CH_N: dec.res[0] = mk_res(KIND_BYTE, 8'h0A, ERR_NONE);
            CH_R: dec.res[0] = mk_res(KIND_BYTE, 8'h0D, ERR_NONE);
            CH_T: dec.res[0] = mk_res(KIND_BYTE, 8'h09, ERR_NONE);
            CH_U: begin
              dec.count     = 3'd0;
              phase_nxt     = PH_HEX1;
              hex_count_nxt = 2'd0;
              hex_accum_nxt = 16'd0;
            end
            default: begin
              dec.res[0]    = mk_res(KIND_ERR, 8'd0, ERR_BAD_ESC);
              phase_nxt     = PH_WAIT;
              hex_count_nxt = 2'd0;
            end
          endcase
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (in_end || !hd[4]) begin
          dec.count = 3'd1;
          dec.res[0] = mk_res(KIND_ERR, 8'd0, in_end ? ERR_HEX_CUT : ERR_NON_HEX);
          phase_nxt = PH_WAIT; hex_count_nxt = 2'd0;
        end else begin
          hex_accum_nxt = quad;
          hex_count_nxt = hex_count_r + 2'd1;
          // Quad complete on the fourth digit
          if (hex_count_r == 2'd3) begin
            if (phase_r == PH_HEX1) begin
              if (quad >= 16'hD800 && quad <= 16'hDBFF) begin
                high_unit_nxt = quad;
                phase_nxt     = PH_BSL;
              end else if (quad >= 16'hDC00 && quad <= 16'hDFFF) begin
                dec.count = 3'd1;
                dec.res[0] = mk_res(KIND_ERR, 8'd0, ERR_LONE_LOW);
                phase_nxt = PH_WAIT;
              end else begin
                dec       = utf8_enc({5'd0, quad});
                phase_nxt = PH_STR;
              end
            end else begin
              if (quad < 16'hDC00 || quad > 16'hDFFF) begin
                dec.count = 3'd1;
                dec.res[0] = mk_res(KIND_ERR, 8'd0, ERR_BAD_PAIR);
                phase_nxt = PH_WAIT;
              end else begin
                dec       = utf8_enc(pair_cp);
                phase_nxt = PH_STR;
              end
            end
          end
        end
      end
      PH_BSL, PH_U: begin
        if (in_end || in_byte != ((phase_r == PH_BSL) ? CH_BSLASH : CH_U)) begin
          dec.count = 3'd1; dec.res[0] = mk_res(KIND_ERR, 8'd0, ERR_LONE_HIGH);
          phase_nxt = PH_WAIT; hex_count_nxt = 2'd0;
        end else if (phase_r == PH_BSL) begin
          phase_nxt = PH_U;
        end else begin
          phase_nxt     = PH_HEX2;
          hex_count_nxt = 2'd0;
          hex_accum_nxt = 16'd0;
        end
      end
      default: begin
        if (in_end || in_byte != CH_QUOTE) begin
          dec.count = 3'd1; dec.res[0] = mk_res(KIND_ERR, 8'd0, ERR_NO_QUOTE);
          phase_nxt = PH_WAIT; hex_count_nxt = 2'd0;
        end else begin
          phase_nxt = PH_STR;
        end
      end
    endcase
  end

  // Advance decoder state once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      hex_count_r <= 2'd0;
      high_unit_r <= 16'd0;
      hex_accum_r <= 16'd0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      hex_count_r <= hex_count_nxt;
      high_unit_r <= high_unit_nxt;
      hex_accum_r <= hex_accum_nxt;
    end
  end

endmodule
